@@ rtl/saf_pkg.sv @@
// saf_pkg: shared constants, types and helpers of the stream find-and-replace block.
// Used by the channel interfaces, the window cell, the top level and the checker.
// Depends on nothing.
package saf_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int NEEDLE_MAX_DEF      = 16;
  localparam int REPLACEMENT_MAX_DEF = 16;
  localparam int OUTPUT_MAX_DEF      = 4096;

  // Fixed field widths.
  localparam int BYTE_W     = 8;
  localparam int STR_BYTES  = 16;
  localparam int STR_W      = STR_BYTES * BYTE_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int LEN_CFG_W  = 5;
  localparam int LIMIT_W    = 12;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = 12'd1023;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_LO = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_HI = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_LEN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPL_LO   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REPL_HI   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REPL_LEN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_LIMIT = 3'd6;

  // Per-cycle control of one window cell.
  typedef struct packed {
    logic load;   // take the incoming text byte
    logic shift;  // take the neighbor's byte (window moves toward cell 0)
  } saf_cell_ctl_t;

  // Pick byte idx out of a 16-byte string, byte 0 in bits 7:0.
  function automatic logic [BYTE_W-1:0] byte_sel(input logic [STR_W-1:0] str,
                                                 input logic [3:0] idx);
    byte_sel = str[idx*BYTE_W +: BYTE_W];
  endfunction

endpackage

@@ rtl/saf_in_if.sv @@
// saf_in_if: request channel carrying haystack bytes into the block.
// Depends on saf_pkg for field widths.
interface saf_in_if;
  logic                        valid;
  logic                        ready;
  logic [saf_pkg::BYTE_W-1:0]  text_byte;
  logic                        final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

@@ rtl/saf_out_if.sv @@
// saf_out_if: result channel carrying output characters and end markers.
// Depends on saf_pkg for field widths.
interface saf_out_if;
  logic                        valid;
  logic                        ready;
  logic [saf_pkg::BYTE_W-1:0]  out_byte;
  logic                        out_valid;
  logic                        out_last;

  modport source (output valid, output out_byte, output out_valid, output out_last,
                  input ready);
  modport sink   (input valid, input out_byte, input out_valid, input out_last,
                  output ready);
endinterface

@@ rtl/saf_cell.sv @@
// saf_cell: one position of the lookahead window, holding a byte and
// comparing it with its needle byte. Depends on saf_pkg.
module saf_cell (
  input  logic                       clk,
  input  saf_pkg::saf_cell_ctl_t     ctl,
  input  logic [saf_pkg::BYTE_W-1:0] in_byte,
  input  logic [saf_pkg::BYTE_W-1:0] nbr_byte,
  input  logic [saf_pkg::BYTE_W-1:0] needle_byte,
  output logic [saf_pkg::BYTE_W-1:0] cell_byte,
  output logic                       eq
);

  logic [saf_pkg::BYTE_W-1:0] byte_r;

  // The byte being written this cycle takes part in the compare at once.
  assign eq        = ((ctl.load ? in_byte : byte_r) == needle_byte);
  assign cell_byte = byte_r;

  // Window content: load from the input or move in from the right neighbor.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      byte_r <= in_byte;
    end else if (ctl.shift) begin
      byte_r <= nbr_byte;
    end
  end

endmodule

@@ rtl/stream_find_and_replace.sv @@
// stream_find_and_replace: streaming literal substring replacement, top level.
// Depends on saf_pkg, saf_in_if, saf_out_if and saf_cell.
//
// Usage:
//   in_ch carries one haystack byte per request, final_byte marking the last
//   byte of a string. out_ch returns output characters; out_valid 0 with
//   out_last 1 is a bare end marker for a final byte that produced nothing.
//   out_last flags the final result of each output string.
//   The cfg_ port writes the needle, replacement and output limit; the user
//   must write them only while the block is idle, which the block does not
//   enforce. Writing the needle length also restarts the current string.
// Sequencing:
//   An accepted request moves the controller to S_RUN, from which its first
//   result is loaded into the output register; then one result per cycle
//   while the output slot is free. Each request drains its candidate bytes
//   (replacement bytes or flushed window bytes, up to 16), taking them from
//   the replacement string or the cell row; the output cap can cut it short.
// Reset: synchronous, active low; clears the window fill, the output count
//   and all configuration to its reset values.
// Stall: while out_ch is not ready the result is held in the output register
//   and the sequencer waits; in_ch.ready is high only between requests.
module stream_find_and_replace #(
  parameter int NEEDLE_MAX      = saf_pkg::NEEDLE_MAX_DEF,
  parameter int REPLACEMENT_MAX = saf_pkg::REPLACEMENT_MAX_DEF,
  parameter int OUTPUT_MAX      = saf_pkg::OUTPUT_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  saf_in_if.sink                         in_ch,
  saf_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [saf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [saf_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int FW = $clog2(NEEDLE_MAX + 1);
  localparam int RW = $clog2(REPLACEMENT_MAX + 1);
  localparam int CW = $clog2(OUTPUT_MAX);
  localparam int BW = saf_pkg::BYTE_W;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  // Configuration registers.
  logic [saf_pkg::STR_W-1:0]     needle_r;
  logic [saf_pkg::STR_W-1:0]     repl_r;
  logic [saf_pkg::LEN_CFG_W-1:0] nlen_cfg_r;
  logic [saf_pkg::LEN_CFG_W-1:0] rlen_cfg_r;
  logic [saf_pkg::LIMIT_W-1:0]   limit_cfg_r;

  // Stream and sequencer state.
  logic          state_r, state_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          lr_r, lr_nxt;
  logic [RW-1:0] rep_left_r, rep_left_nxt;
  logic [RW-1:0] rep_idx_r, rep_idx_nxt;
  logic [FW-1:0] pop_left_r, pop_left_nxt;
  logic          fin_r, fin_nxt;
  logic          echo_r, echo_nxt;
  logic          any_r, any_nxt;

  // Output register.
  logic          ovld_r, ovld_nxt;
  logic [BW-1:0] obyte_r, obyte_nxt;
  logic          ochar_r, ochar_nxt;
  logic          olast_r, olast_nxt;

  // Derived values.
  logic [FW-1:0] nlen;
  logic [RW-1:0] rlen;
  logic [CW-1:0] lim;
  logic [FW-1:0] fill_inc;
  logic [CW-1:0] cnt_inc;
  logic          in_acc, slot_free, full, match;
  logic          have_rep, have_pop, capped, reach, last_cand;
  logic          pop_evt;

  // Window cell row.
  saf_pkg::saf_cell_ctl_t cell_ctl [NEEDLE_MAX];
  logic [BW-1:0]          cell_byte [NEEDLE_MAX];
  logic [NEEDLE_MAX-1:0]  cell_eq;
  logic [NEEDLE_MAX-1:0]  cell_used;

  // Saturate the configured lengths and the output limit.
  assign nlen = (nlen_cfg_r > saf_pkg::LEN_CFG_W'(NEEDLE_MAX)) ? FW'(NEEDLE_MAX)
                                                                : FW'(nlen_cfg_r);
  assign rlen = (rlen_cfg_r > saf_pkg::LEN_CFG_W'(REPLACEMENT_MAX)) ? RW'(REPLACEMENT_MAX)
                                                                     : RW'(rlen_cfg_r);
  assign lim  = (limit_cfg_r > saf_pkg::LIMIT_W'(OUTPUT_MAX - 1)) ? CW'(OUTPUT_MAX - 1)
                                                                   : CW'(limit_cfg_r);

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign slot_free = !ovld_r || out_ch.ready;
  assign fill_inc  = fill_r + 1'b1;
  assign cnt_inc   = cnt_r + 1'b1;
  assign full      = (fill_inc == nlen);
  assign match     = full && (&(cell_eq | ~cell_used));

  assign have_rep  = (rep_left_r != '0);
  assign have_pop  = (pop_left_r != '0);
  assign capped    = !echo_r && (lr_r || (cnt_r >= lim));
  assign reach     = !echo_r && (cnt_inc >= lim);
  assign last_cand = have_rep ? ((rep_left_r == RW'(1)) && !have_pop)
                              : (pop_left_r == FW'(1));

  // Cells: cell 0 holds the oldest byte; the row moves left on each pop.
  for (genvar i = 0; i < NEEDLE_MAX; i++) begin : g_cell
    logic [BW-1:0] nbr;

    if (i == NEEDLE_MAX - 1) begin : g_end
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_byte[i+1];
    end

    assign cell_ctl[i].load  = in_acc && (fill_r == FW'(i));
    assign cell_ctl[i].shift = pop_evt;
    assign cell_used[i]      = (FW'(i) < nlen);

    saf_cell u_cell (
      .clk         (clk),
      .ctl         (cell_ctl[i]),
      .in_byte     (in_ch.text_byte),
      .nbr_byte    (nbr),
      .needle_byte (needle_r[i*BW +: BW]),
      .cell_byte   (cell_byte[i]),
      .eq          (cell_eq[i])
    );
  end

  // Sequencer: set up a request, drain candidates one a cycle when unstalled.
  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    cnt_nxt      = cnt_r;
    lr_nxt       = lr_r;
    rep_left_nxt = rep_left_r;
    rep_idx_nxt  = rep_idx_r;
    pop_left_nxt = pop_left_r;
    fin_nxt      = fin_r;
    echo_nxt     = echo_r;
    any_nxt      = any_r;
    ovld_nxt     = ovld_r && !out_ch.ready;
    obyte_nxt    = obyte_r;
    ochar_nxt    = ochar_r;
    olast_nxt    = olast_r;
    pop_evt      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt    = S_RUN;
          fin_nxt      = in_ch.final_byte;
          any_nxt      = 1'b0;
          echo_nxt     = (nlen == '0);
          rep_idx_nxt  = '0;
          rep_left_nxt = '0;
          if (nlen == '0) begin
            // Empty needle: the byte sits in cell 0 and is echoed uncapped.
            pop_left_nxt = FW'(1);
          end else if (match) begin
            fill_nxt     = '0;
            rep_left_nxt = rlen;
            pop_left_nxt = '0;
          end else begin
            fill_nxt     = fill_inc;
            pop_left_nxt = in_ch.final_byte ? fill_inc : (full ? FW'(1) : FW'(0));
          end
        end
      end
      S_RUN: begin
        if (slot_free) begin
          if (have_rep || have_pop) begin
            if (capped) begin
              // Cap hit: drop the rest; retire the oldest byte unless final.
              lr_nxt       = 1'b1;
              rep_left_nxt = '0;
              pop_left_nxt = '0;
              if (have_pop && !fin_r) begin
                pop_evt  = 1'b1;
                fill_nxt = fill_r - 1'b1;
              end
            end else begin
              ovld_nxt  = 1'b1;
              ochar_nxt = 1'b1;
              olast_nxt = fin_r && (last_cand || reach);
              any_nxt   = 1'b1;
              if (!echo_r) begin
                cnt_nxt = cnt_inc;
                if (reach) begin
                  lr_nxt = 1'b1;
                end
              end
              if (have_rep) begin
                obyte_nxt    = saf_pkg::byte_sel(repl_r, 4'(rep_idx_r));
                rep_left_nxt = rep_left_r - 1'b1;
                rep_idx_nxt  = rep_idx_r + 1'b1;
              end else begin
                obyte_nxt    = cell_byte[0];
                pop_evt      = 1'b1;
                pop_left_nxt = pop_left_r - 1'b1;
                if (!echo_r) begin
                  fill_nxt = fill_r - 1'b1;
                end
              end
            end
          end else begin
            // Request done; a final byte with no character gets an end marker.
            state_nxt = S_IDLE;
            if (fin_r) begin
              fill_nxt = '0;
              cnt_nxt  = '0;
              lr_nxt   = 1'b0;
              if (!any_r) begin
                ovld_nxt  = 1'b1;
                ochar_nxt = 1'b0;
                olast_nxt = 1'b1;
                obyte_nxt = '0;
              end
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A new needle length restarts the string.
    if (cfg_we && (cfg_index == saf_pkg::CFG_NEEDLE_LEN)) begin
      fill_nxt = '0;
      cnt_nxt  = '0;
      lr_nxt   = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      fill_r     <= '0;
      cnt_r      <= '0;
      lr_r       <= 1'b0;
      rep_left_r <= '0;
      pop_left_r <= '0;
      ovld_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      fill_r     <= fill_nxt;
      cnt_r      <= cnt_nxt;
      lr_r       <= lr_nxt;
      rep_left_r <= rep_left_nxt;
      pop_left_r <= pop_left_nxt;
      ovld_r     <= ovld_nxt;
    end
  end

  // Payload and per-request registers.
  always_ff @(posedge clk) begin
    rep_idx_r <= rep_idx_nxt;
    fin_r     <= fin_nxt;
    echo_r    <= echo_nxt;
    any_r     <= any_nxt;
    obyte_r   <= obyte_nxt;
    ochar_r   <= ochar_nxt;
    olast_r   <= olast_nxt;
  end

  // Configuration write port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      needle_r    <= '0;
      repl_r      <= '0;
      nlen_cfg_r  <= '0;
      rlen_cfg_r  <= '0;
      limit_cfg_r <= saf_pkg::LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        saf_pkg::CFG_NEEDLE_LO:  needle_r[63:0]   <= cfg_data;
        saf_pkg::CFG_NEEDLE_HI:  needle_r[127:64] <= cfg_data;
        saf_pkg::CFG_NEEDLE_LEN: nlen_cfg_r  <= cfg_data[saf_pkg::LEN_CFG_W-1:0];
        saf_pkg::CFG_REPL_LO:    repl_r[63:0]     <= cfg_data;
        saf_pkg::CFG_REPL_HI:    repl_r[127:64]   <= cfg_data;
        saf_pkg::CFG_REPL_LEN:   rlen_cfg_r  <= cfg_data[saf_pkg::LEN_CFG_W-1:0];
        saf_pkg::CFG_OUT_LIMIT:  limit_cfg_r <= cfg_data[saf_pkg::LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Channel outputs.
  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = ovld_r;
  assign out_ch.out_byte  = obyte_r;
  assign out_ch.out_valid = ochar_r;
  assign out_ch.out_last  = olast_r;

endmodule

@@ rtl/saf_chk.sv @@
// saf_chk: port-level checks of stream_find_and_replace, attached by bind.
// Depends on saf_pkg; sees only the top-level ports.
module saf_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_vld,
  input logic                       out_rdy,
  input logic [saf_pkg::BYTE_W-1:0] out_byte,
  input logic                       out_char,
  input logic                       out_last
);

  // A stalled result keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld && !out_rdy) |=> (out_vld && $stable(out_byte) && $stable(out_char)
                               && $stable(out_last)))
    else $error("stalled result changed");

  // One request at a time: an accepted request closes the input side.
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a request is in progress");

  // A bare end marker always closes the string.
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld && !out_char) |-> (out_last && (out_byte == '0)))
    else $error("end marker without last flag");

  // Nothing is offered right after reset.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_vld)
    else $error("result offered after reset");

endmodule

bind stream_find_and_replace saf_chk u_saf_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_ch.valid),
  .in_ready (in_ch.ready),
  .out_vld  (out_ch.valid),
  .out_rdy  (out_ch.ready),
  .out_byte (out_ch.out_byte),
  .out_char (out_ch.out_valid),
  .out_last (out_ch.out_last)
);
